@@ rtl/raster_chain_code_extractor_assert.svh @@
// Assertion helpers for the RTL, included by rcce_back; expects clk_i and rst_ni in scope.
`ifndef RASTER_CHAIN_CODE_EXTRACTOR_ASSERT_SVH
`define RASTER_CHAIN_CODE_EXTRACTOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RCCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rcce_pkg.sv @@
package rcce_pkg;

  localparam int unsigned MaxActiveDef   = 2048;
  localparam int unsigned MaxElementsDef = 65536;
  localparam int unsigned MaxResults     = 12;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned NumShapes      = 14;
  localparam int unsigned NumLinks       = 8;
  localparam int unsigned FlagW          = 12;

  // flag word bit positions
  localparam int unsigned FlagLk0a = 11;
  localparam int unsigned FlagLk0b = 10;
  localparam int unsigned FlagLk3a = 5;
  localparam int unsigned FlagLk3b = 4;
  localparam int unsigned FlagMino = 3;
  localparam int unsigned FlagMini = 2;
  localparam int unsigned FlagMaxo = 1;
  localparam int unsigned FlagMaxi = 0;

  // outer min plus outer max only: isolated pixel
  localparam logic [FlagW-1:0] IsoFlags = FlagW'((1 << FlagMino) | (1 << FlagMaxo));

  // templates in neighbourhood bit layout: X=8, A..H=7..0
  localparam logic [8:0] ShapeMask [NumShapes] = '{
    9'h1D0, 9'h116, 9'h1C0, 9'h190, 9'h1D0, 9'h168, 9'h160,
    9'h128, 9'h10F, 9'h1F0, 9'h1E0, 9'h1F0, 9'h10F, 9'h107};
  localparam logic [8:0] ShapeVal [NumShapes] = '{
    9'h110, 9'h110, 9'h180, 9'h180, 9'h140, 9'h140, 9'h120,
    9'h120, 9'h100, 9'h130, 9'h1A0, 9'h100, 9'h10C, 9'h105};

  typedef enum logic [1:0] {
    EV_NEW    = 2'd0,
    EV_APPEND = 2'd1,
    EV_LINK   = 2'd2
  } event_kind_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RWD_RD, S_RWD_WR, S_DISPATCH, S_DEC_RD, S_DEC_WR,
    S_LINK, S_LINK_WR, S_JOIN0, S_JN_A, S_JN_B, S_JN_C, S_JN_D,
    S_MAX, S_MAXO_I2, S_MAXI, S_MAXI_WB, S_MAXI_I1, S_MAXI_I2,
    S_MAXI_FW, S_DONE, S_DRAIN
  } state_e;

  typedef struct packed {
    logic [8:0]  neighbourhood;
    logic [10:0] row;
    logic [10:0] col;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] element_id;
    logic        chain_side;
    logic [1:0]  direction;
    logic [15:0] target_id;
    logic [10:0] event_row;
    logic [10:0] event_col;
    logic        overflow;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [FlagW-1:0] flags;
    logic [10:0]      row;
    logic [10:0]      col;
  } job_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic        side;
    logic [1:0]  dir;
    logic [15:0] tgt;
  } rec_t;

  function automatic logic [FlagW-1:0] classify(logic [8:0] nb);
    logic [NumShapes-1:0] hit;
    logic [FlagW-1:0]     s;
    for (int k = 0; k < NumShapes; k++) begin
      hit[k] = ((nb & ShapeMask[k]) == ShapeVal[k]);
    end
    s = '0;
    for (int i = 0; i < NumLinks; i++) begin
      s[FlagLk0a - i] = hit[i];
    end
    s[FlagMino] = hit[8];
    s[FlagMini] = hit[9] | hit[10];
    s[FlagMaxo] = hit[11];
    s[FlagMaxi] = hit[12] | hit[13];
    return s;
  endfunction

endpackage

@@ rtl/raster_chain_code_extractor.sv @@
// Raster chain code extractor.
// in channel  (in_valid_i/in_ready_o/in_word_i): one pixel word per handshake,
//   its 3x3 neighbourhood plus row and column, in raster order.
// out channel (out_valid_o/out_ready_i/out_word_o): one event word per
//   handshake; last marks the final event of a pixel, a pixel with no events
//   gives no word.
// The front classifies a pixel against the templates in the accept cycle and
// queues it (two entries). The back walks the open chain ends of the list
// memory, one read and one write per cycle, and buffers the events of the
// pixel, then shifts them out through an output register.
// The back takes the next pixel from the queue only once it is done with the
// last one; a pixel at column 0 first moves every chain end left of the cursor
// over to the back stack.
// A stalled receiver holds the output register; the back stops at its drain
// step and the queue fills, then in_ready_o drops.
// Reset empties the chain end list and the queue and clears the element
// count and the overflow flag; no clearing pass is needed.
module raster_chain_code_extractor #(
  parameter int unsigned MAX_ACTIVE   = rcce_pkg::MaxActiveDef,
  parameter int unsigned MAX_ELEMENTS = rcce_pkg::MaxElementsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rcce_pkg::pixel_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rcce_pkg::event_t out_word_o
);

  logic           fr_valid, fr_ready, q_valid, q_ready;
  rcce_pkg::job_t fr_job, q_job;

  rcce_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  rcce_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_i       (fr_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_job)
  );

  rcce_back #(
    .MAX_ACTIVE   (MAX_ACTIVE),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/rcce_front.sv @@
module rcce_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rcce_pkg::pixel_t in_word_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output rcce_pkg::job_t  job_o
);

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;

  always_comb begin
    job_o.flags = rcce_pkg::classify(in_word_i.neighbourhood);
    job_o.row   = in_word_i.row;
    job_o.col   = in_word_i.col;
  end

endmodule

@@ rtl/rcce_fifo.sv @@
module rcce_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rcce_pkg::job_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rcce_pkg::job_t pop_o
);

  localparam int unsigned PtrW = $clog2(rcce_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(rcce_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rcce_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(rcce_pkg::QueueDepth);

  rcce_pkg::job_t  mem_q [rcce_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i;
    end
  end

endmodule

@@ rtl/rcce_back.sv @@
module rcce_back #(
  parameter int unsigned MAX_ACTIVE   = rcce_pkg::MaxActiveDef,
  parameter int unsigned MAX_ELEMENTS = rcce_pkg::MaxElementsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  rcce_pkg::job_t   job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rcce_pkg::event_t out_word_o
);

  `include "raster_chain_code_extractor_assert.svh"

  localparam int unsigned AW  = $clog2(MAX_ACTIVE);
  localparam int unsigned CW  = $clog2(MAX_ACTIVE + 1);
  localparam int unsigned IW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned ECW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned EW  = IW + 1;
  localparam int unsigned NW  = $clog2(rcce_pkg::MaxResults + 1);
  localparam int unsigned BW  = $clog2(rcce_pkg::MaxResults);
  localparam logic [CW-1:0]  MaxA   = CW'(MAX_ACTIVE);
  localparam logic [ECW-1:0] MaxE   = ECW'(MAX_ELEMENTS);
  localparam logic [IW-1:0]  LastId = IW'(MAX_ELEMENTS - 1);
  localparam logic [NW-1:0]  MaxRes = NW'(rcce_pkg::MaxResults);
  localparam logic [3:0]     LinkEnd = 4'(rcce_pkg::NumLinks);

  // list split at the cursor: front stack grows up from 0, back stack down from the top
  logic [EW-1:0] list_mem [MAX_ACTIVE];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata;

  rcce_pkg::rec_t ev_buf [rcce_pkg::MaxResults];

  rcce_pkg::state_e state_q, state_d;
  logic [CW-1:0]   fcnt_q, fcnt_d, bcnt_q, bcnt_d;
  logic [ECW-1:0]  ecnt_q, ecnt_d;
  logic            ovf_q, ovf_d;
  logic [NW-1:0]   evn_q, evn_d, evi_q, evi_d;
  logic [3:0]      li_q, li_d;
  logic [1:0]      dec_q, dec_d;
  logic            right_q, right_d, back_q, back_d, j2_q, j2_d, jcm1_q, jcm1_d;
  logic            out_valid_q, out_valid_d;
  rcce_pkg::event_t out_q, out_d;
  logic [rcce_pkg::FlagW-1:0] flags_q, flags_d;
  logic [10:0]     row_q, row_d, col_q, col_d;
  logic [EW-1:0]   fst_q, fst_d;
  logic [IW-1:0]   id_q, id_d;

  logic [CW-1:0]   fm1_w, fm2_w, fm3_w, btop_w, bpush_w;
  logic [CW:0]     len_w;
  logic [IW-1:0]   new_id;
  logic            new_req, ins_req, emit_en;
  logic [EW-1:0]   ins_entry;
  rcce_pkg::rec_t  emit_rec;
  logic [rcce_pkg::NumLinks-1:0] link_w;
  logic [3:0]      links_w;
  rcce_pkg::rec_t  drain_rec;

  assign fm1_w   = fcnt_q - CW'(1);
  assign fm2_w   = fcnt_q - CW'(2);
  assign fm3_w   = fcnt_q - CW'(3);
  assign btop_w  = MaxA - bcnt_q;
  assign bpush_w = MaxA - bcnt_q - CW'(1);
  assign len_w   = {1'b0, fcnt_q} + {1'b0, bcnt_q};
  assign new_id  = (ecnt_q >= MaxE) ? LastId : ecnt_q[IW-1:0];
  assign link_w  = flags_q[rcce_pkg::FlagLk0a -: rcce_pkg::NumLinks];
  assign links_w = 4'($countones(link_w));
  assign drain_rec = ev_buf[evi_q[BW-1:0]];

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    fcnt_d      = fcnt_q;
    bcnt_d      = bcnt_q;
    ecnt_d      = ecnt_q;
    ovf_d       = ovf_q;
    evn_d       = evn_q;
    evi_d       = evi_q;
    li_d        = li_q;
    dec_d       = dec_q;
    right_d     = right_q;
    back_d      = back_q;
    j2_d        = j2_q;
    jcm1_d      = jcm1_q;
    flags_d     = flags_q;
    row_d       = row_q;
    col_d       = col_q;
    fst_d       = fst_q;
    id_d        = id_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    new_req     = 1'b0;
    ins_req     = 1'b0;
    ins_entry   = '0;
    emit_en     = 1'b0;
    emit_rec    = '0;
    job_ready_o = 1'b0;

    case (state_q)
      rcce_pkg::S_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          flags_d = job_i.flags;
          row_d   = job_i.row;
          col_d   = job_i.col;
          evn_d   = '0;
          evi_d   = '0;
          if (job_i.col == '0 && fcnt_q != '0) begin
            state_d = rcce_pkg::S_RWD_RD;
          end else begin
            state_d = rcce_pkg::S_DISPATCH;
          end
        end
      end
      // column 0: move every front entry over to the back stack
      rcce_pkg::S_RWD_RD: begin
        mem_raddr = fm1_w[AW-1:0];
        state_d   = rcce_pkg::S_RWD_WR;
      end
      rcce_pkg::S_RWD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bpush_w[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fm1_w;
        bcnt_d    = bcnt_q + CW'(1);
        state_d   = (fm1_w == '0) ? rcce_pkg::S_DISPATCH : rcce_pkg::S_RWD_RD;
      end
      rcce_pkg::S_DISPATCH: begin
        if (flags_q == '0) begin
          state_d = rcce_pkg::S_DONE;
        end else if (flags_q == rcce_pkg::IsoFlags) begin
          new_req     = 1'b1;
          emit_en     = 1'b1;
          emit_rec.kind = rcce_pkg::EV_NEW;
          emit_rec.id   = 16'(new_id);
          state_d     = rcce_pkg::S_DONE;
        end else begin
          dec_d   = {flags_q[rcce_pkg::FlagLk0a] & flags_q[rcce_pkg::FlagLk0b],
                     flags_q[rcce_pkg::FlagLk0a] ^ flags_q[rcce_pkg::FlagLk0b]};
          right_d = 1'b0;
          li_d    = '0;
          state_d = rcce_pkg::S_DEC_RD;
        end
      end
      rcce_pkg::S_DEC_RD: begin
        if (dec_q == '0 || fcnt_q == '0) begin
          state_d = rcce_pkg::S_LINK;
        end else begin
          mem_raddr = fm1_w[AW-1:0];
          state_d   = rcce_pkg::S_DEC_WR;
        end
      end
      rcce_pkg::S_DEC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bpush_w[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fm1_w;
        bcnt_d    = bcnt_q + CW'(1);
        dec_d     = dec_q - 2'd1;
        state_d   = rcce_pkg::S_DEC_RD;
      end
      rcce_pkg::S_LINK: begin
        if (li_q == LinkEnd) begin
          state_d = rcce_pkg::S_JOIN0;
        end else if (link_w[3'(rcce_pkg::NumLinks - 1) - li_q[2:0]] && bcnt_q != '0) begin
          mem_raddr = btop_w[AW-1:0];
          state_d   = rcce_pkg::S_LINK_WR;
        end else begin
          li_d = li_q + 4'd1;
        end
      end
      rcce_pkg::S_LINK_WR: begin
        emit_en       = 1'b1;
        emit_rec.kind = rcce_pkg::EV_APPEND;
        emit_rec.id   = 16'(rdata_q[EW-1:1]);
        emit_rec.side = rdata_q[0];
        emit_rec.dir  = li_q[2:1];
        right_d   = rdata_q[0];
        mem_we    = 1'b1;
        mem_waddr = fcnt_q[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fcnt_q + CW'(1);
        bcnt_d    = bcnt_q - CW'(1);
        li_d      = li_q + 4'd1;
        state_d   = rcce_pkg::S_LINK;
      end
      rcce_pkg::S_JOIN0: begin
        if (flags_q[rcce_pkg::FlagMino] && flags_q[rcce_pkg::FlagMini]) begin
          jcm1_d  = 1'b1;
          j2_d    = 1'b1;
          state_d = rcce_pkg::S_JN_A;
        end else if (flags_q[rcce_pkg::FlagMino] || flags_q[rcce_pkg::FlagMini]) begin
          j2_d    = 1'b0;
          jcm1_d  = !(links_w == 4'd2 || (links_w == 4'd3 &&
                    !(flags_q[rcce_pkg::FlagLk3a] && flags_q[rcce_pkg::FlagLk3b])));
          state_d = rcce_pkg::S_JN_A;
        end else begin
          state_d = rcce_pkg::S_MAX;
        end
      end
      // join the two ends just below the cursor, or below the entry under it
      rcce_pkg::S_JN_A: begin
        if (fcnt_q < (jcm1_q ? CW'(3) : CW'(2))) begin
          if (j2_q) begin
            j2_d    = 1'b0;
            jcm1_d  = 1'b0;
            state_d = rcce_pkg::S_JN_A;
          end else begin
            state_d = rcce_pkg::S_MAX;
          end
        end else begin
          mem_raddr = jcm1_q ? fm2_w[AW-1:0] : fm1_w[AW-1:0];
          state_d   = rcce_pkg::S_JN_B;
        end
      end
      rcce_pkg::S_JN_B: begin
        fst_d     = rdata_q;
        mem_raddr = jcm1_q ? fm3_w[AW-1:0] : fm2_w[AW-1:0];
        state_d   = rcce_pkg::S_JN_C;
      end
      rcce_pkg::S_JN_C: begin
        emit_en       = 1'b1;
        emit_rec.kind = rcce_pkg::EV_LINK;
        if (fst_q[0]) begin
          emit_rec.id  = 16'(fst_q[EW-1:1]);
          emit_rec.tgt = 16'(rdata_q[EW-1:1]);
        end else begin
          emit_rec.id  = 16'(rdata_q[EW-1:1]);
          emit_rec.tgt = 16'(fst_q[EW-1:1]);
        end
        if (jcm1_q) begin
          mem_raddr = fm1_w[AW-1:0];
          state_d   = rcce_pkg::S_JN_D;
        end else begin
          fcnt_d = fm2_w;
          if (j2_q) begin
            j2_d    = 1'b0;
            jcm1_d  = 1'b0;
            state_d = rcce_pkg::S_JN_A;
          end else begin
            state_d = rcce_pkg::S_MAX;
          end
        end
      end
      rcce_pkg::S_JN_D: begin
        mem_we    = 1'b1;
        mem_waddr = fm3_w[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fm2_w;
        if (j2_q) begin
          j2_d    = 1'b0;
          jcm1_d  = 1'b0;
          state_d = rcce_pkg::S_JN_A;
        end else begin
          state_d = rcce_pkg::S_MAX;
        end
      end
      rcce_pkg::S_MAX: begin
        if (flags_q[rcce_pkg::FlagMaxo]) begin
          new_req       = 1'b1;
          emit_en       = 1'b1;
          emit_rec.kind = rcce_pkg::EV_NEW;
          emit_rec.id   = 16'(new_id);
          id_d          = new_id;
          ins_req       = 1'b1;
          ins_entry     = {new_id, 1'b0};
          state_d       = rcce_pkg::S_MAXO_I2;
        end else begin
          state_d = rcce_pkg::S_MAXI;
        end
      end
      rcce_pkg::S_MAXO_I2: begin
        ins_req   = 1'b1;
        ins_entry = {id_q, 1'b1};
        right_d   = 1'b1;
        state_d   = rcce_pkg::S_MAXI;
      end
      rcce_pkg::S_MAXI: begin
        if (flags_q[rcce_pkg::FlagMaxi]) begin
          new_req       = 1'b1;
          emit_en       = 1'b1;
          emit_rec.kind = rcce_pkg::EV_NEW;
          emit_rec.id   = 16'(new_id);
          id_d          = new_id;
          back_d        = 1'b0;
          if (right_q && fcnt_q != '0) begin
            mem_raddr = fm1_w[AW-1:0];
            state_d   = rcce_pkg::S_MAXI_WB;
          end else begin
            state_d = rcce_pkg::S_MAXI_I1;
          end
        end else begin
          state_d = rcce_pkg::S_DONE;
        end
      end
      rcce_pkg::S_MAXI_WB: begin
        mem_we    = 1'b1;
        mem_waddr = bpush_w[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fm1_w;
        bcnt_d    = bcnt_q + CW'(1);
        back_d    = 1'b1;
        state_d   = rcce_pkg::S_MAXI_I1;
      end
      rcce_pkg::S_MAXI_I1: begin
        ins_req   = 1'b1;
        ins_entry = {id_q, 1'b1};
        state_d   = rcce_pkg::S_MAXI_I2;
      end
      rcce_pkg::S_MAXI_I2: begin
        ins_req   = 1'b1;
        ins_entry = {id_q, 1'b0};
        if (back_q && bcnt_q != '0) begin
          mem_raddr = btop_w[AW-1:0];
          state_d   = rcce_pkg::S_MAXI_FW;
        end else begin
          state_d = rcce_pkg::S_DONE;
        end
      end
      rcce_pkg::S_MAXI_FW: begin
        mem_we    = 1'b1;
        mem_waddr = fcnt_q[AW-1:0];
        mem_wdata = rdata_q;
        fcnt_d    = fcnt_q + CW'(1);
        bcnt_d    = bcnt_q - CW'(1);
        state_d   = rcce_pkg::S_DONE;
      end
      rcce_pkg::S_DONE: begin
        state_d = (evn_q == '0) ? rcce_pkg::S_IDLE : rcce_pkg::S_DRAIN;
      end
      rcce_pkg::S_DRAIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.event_kind = drain_rec.kind;
          out_d.element_id = drain_rec.id;
          out_d.chain_side = drain_rec.side;
          out_d.direction  = drain_rec.dir;
          out_d.target_id  = drain_rec.tgt;
          out_d.event_row  = row_q;
          out_d.event_col  = col_q;
          out_d.overflow   = ovf_q;
          out_d.last       = (evi_q == evn_q - NW'(1));
          out_valid_d      = 1'b1;
          evi_d            = evi_q + NW'(1);
          if (evi_q == evn_q - NW'(1)) begin
            state_d = rcce_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = rcce_pkg::S_IDLE;
      end
    endcase

    if (new_req) begin
      if (ecnt_q >= MaxE) begin
        ovf_d = 1'b1;
      end else begin
        ecnt_d = ecnt_q + ECW'(1);
      end
    end
    // insertion at the cursor is a push on the front stack
    if (ins_req) begin
      if (len_w >= {1'b0, MaxA}) begin
        ovf_d = 1'b1;
      end else begin
        mem_we    = 1'b1;
        mem_waddr = fcnt_q[AW-1:0];
        mem_wdata = ins_entry;
        fcnt_d    = fcnt_q + CW'(1);
      end
    end
    if (emit_en && evn_q < MaxRes) begin
      evn_d = evn_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcce_pkg::S_IDLE;
      fcnt_q      <= '0;
      bcnt_q      <= '0;
      ecnt_q      <= '0;
      ovf_q       <= 1'b0;
      evn_q       <= '0;
      evi_q       <= '0;
      li_q        <= '0;
      dec_q       <= '0;
      right_q     <= 1'b0;
      back_q      <= 1'b0;
      j2_q        <= 1'b0;
      jcm1_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fcnt_q      <= fcnt_d;
      bcnt_q      <= bcnt_d;
      ecnt_q      <= ecnt_d;
      ovf_q       <= ovf_d;
      evn_q       <= evn_d;
      evi_q       <= evi_d;
      li_q        <= li_d;
      dec_q       <= dec_d;
      right_q     <= right_d;
      back_q      <= back_d;
      j2_q        <= j2_d;
      jcm1_q      <= jcm1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    row_q   <= row_d;
    col_q   <= col_d;
    fst_q   <= fst_d;
    id_q    <= id_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (emit_en && evn_q < MaxRes) begin
      ev_buf[evn_q[BW-1:0]] <= emit_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= list_mem[mem_raddr];
  end

  `RCCE_ASSERT_NOW(a_list_cap, 1'b1, len_w <= {1'b0, MaxA}, "active list over capacity")
  `RCCE_ASSERT_NOW(a_elem_cap, 1'b1, ecnt_q <= MaxE, "element count over limit")
  `RCCE_ASSERT_NOW(a_drain_idx, state_q == rcce_pkg::S_DRAIN,
                   evn_q != '0 && evi_q < evn_q, "drain index outside event buffer")
  `RCCE_ASSERT_NEXT(a_ovf_sticky, ovf_q, ovf_q, "overflow flag cleared")
  `RCCE_ASSERT_NEXT(a_new_pixel, job_valid_i && job_ready_o, evn_q == '0,
                    "event buffer not empty at pixel start")

endmodule
